>>> hdl/rlps_pkg.sv
// Shared constants and types for the RGB LED pulse serializer.
package rlps_pkg;

	localparam int DEF_MAX_SLOTS = 4;
	localparam int SLOT_CODE_W   = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 20;
	localparam int TIME_W        = 8;
	localparam int GAP_W         = 20;
	localparam int CNT_W         = 3;
	localparam int ORDER_W       = 12;
	localparam int KIND_W        = 2;
	localparam int BIT_W         = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_CNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_ORD  = 3'd6;

	// register reset values
	localparam logic [TIME_W-1:0]  RST_ONE_HIGH  = 8'd34;
	localparam logic [TIME_W-1:0]  RST_ONE_LOW   = 8'd29;
	localparam logic [TIME_W-1:0]  RST_ZERO_HIGH = 8'd17;
	localparam logic [TIME_W-1:0]  RST_ZERO_LOW  = 8'd38;
	localparam logic [GAP_W-1:0]   RST_GAP       = 20'd2400;
	localparam logic [CNT_W-1:0]   RST_SLOT_CNT  = 3'd3;
	localparam logic [ORDER_W-1:0] RST_SLOT_ORD  = 12'd200;

	// slot codes
	localparam logic [SLOT_CODE_W-1:0] CODE_WHITE = 3'd0;
	localparam logic [SLOT_CODE_W-1:0] CODE_RED   = 3'd1;
	localparam logic [SLOT_CODE_W-1:0] CODE_GREEN = 3'd2;
	localparam logic [SLOT_CODE_W-1:0] CODE_BLUE  = 3'd3;

	// pulse kinds
	localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ONE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GAP   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

	// result source select
	localparam logic [1:0] SEL_BIT = 2'd0;
	localparam logic [1:0] SEL_GAP = 2'd1;
	localparam logic [1:0] SEL_ERR = 2'd2;

	typedef struct packed {
		logic       in_ready;
		logic       load;
		logic       emit;
		logic [1:0] sel;
		logic       last_run;
		logic       next_bit;
		logic       next_slot;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic count_zero;
		logic out_free;
		logic slot_invalid;
		logic bit_done;
		logic slot_done;
		logic last;
	} dp_stat_t;

endpackage

>>> hdl/rlps_intf.sv
// Pixel and pulse channel interfaces.
interface rlps_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;

	modport source (output valid, red, green, blue, last_pixel, input ready);
	modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rlps_pulse_if;
	logic        valid;
	logic        ready;
	logic [1:0]  pulse_kind;
	logic [7:0]  high_time;
	logic [19:0] low_time;
	logic        last_of_run;

	modport source (output valid, pulse_kind, high_time, low_time, last_of_run, input ready);
	modport sink (input valid, pulse_kind, high_time, low_time, last_of_run, output ready);
endinterface

>>> hdl/rlps_dp.sv
// Datapath: config registers, pixel hold, slot/bit counters, result register.
module rlps_dp
	import rlps_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rlps_pix_if.sink              pix,
	rlps_pulse_if.source          pulse,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

	logic [TIME_W-1:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
	logic [GAP_W-1:0]   gap_q;
	logic [CNT_W-1:0]   slot_cnt_q;
	logic [ORDER_W-1:0] slot_ord_q;

	logic [23:0]        pixel_q;
	logic               last_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [BIT_W-1:0]   bit_q;

	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [TIME_W-1:0]  high_q;
	logic [GAP_W-1:0]   low_q;
	logic               run_last_q;

	logic [CNT_W-1:0]       count_sat;
	logic [SLOT_CODE_W-1:0] code;
	logic [7:0]             byte_sel;
	logic                   code_bad;
	logic                   bit_val;
	logic [KIND_W-1:0]      kind_d;
	logic [TIME_W-1:0]      high_d;
	logic [GAP_W-1:0]       low_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= RST_ONE_HIGH;
			one_low_q   <= RST_ONE_LOW;
			zero_high_q <= RST_ZERO_HIGH;
			zero_low_q  <= RST_ZERO_LOW;
			gap_q       <= RST_GAP;
			slot_cnt_q  <= RST_SLOT_CNT;
			slot_ord_q  <= RST_SLOT_ORD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ONE_HIGH:  one_high_q  <= cfg_data[TIME_W-1:0];
				REG_ONE_LOW:   one_low_q   <= cfg_data[TIME_W-1:0];
				REG_ZERO_HIGH: zero_high_q <= cfg_data[TIME_W-1:0];
				REG_ZERO_LOW:  zero_low_q  <= cfg_data[TIME_W-1:0];
				REG_GAP:       gap_q       <= cfg_data[GAP_W-1:0];
				REG_SLOT_CNT:  slot_cnt_q  <= cfg_data[CNT_W-1:0];
				REG_SLOT_ORD:  slot_ord_q  <= cfg_data[ORDER_W-1:0];
				default: ;
			endcase
		end
	end

	assign count_sat = (slot_cnt_q > MAX_CNT) ? MAX_CNT : slot_cnt_q;
	assign code      = slot_ord_q[SLOT_CODE_W*slot_q +: SLOT_CODE_W];

	always_comb begin
		byte_sel = 8'd0;
		code_bad = 1'b0;
		unique case (code)
			CODE_WHITE: byte_sel = 8'd0;
			CODE_RED:   byte_sel = pixel_q[23:16];
			CODE_GREEN: byte_sel = pixel_q[15:8];
			CODE_BLUE:  byte_sel = pixel_q[7:0];
			default:    code_bad = 1'b1;
		endcase
	end

	assign bit_val = byte_sel[bit_q];

	// pixel hold and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			bit_q  <= '1;
		end else if (cmd.load) begin
			slot_q <= '0;
			bit_q  <= '1;
		end else begin
			if (cmd.next_bit)
				bit_q <= bit_q - BIT_W'(1);
			if (cmd.next_slot)
				slot_q <= slot_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_q <= {pix.red, pix.green, pix.blue};
			last_q  <= pix.last_pixel;
		end
	end

	always_comb begin
		kind_d = KIND_ERROR;
		high_d = '0;
		low_d  = '0;
		case (cmd.sel)
			SEL_BIT: begin
				kind_d = bit_val ? KIND_ONE : KIND_ZERO;
				high_d = bit_val ? one_high_q : zero_high_q;
				low_d  = GAP_W'(bit_val ? one_low_q : zero_low_q);
			end
			SEL_GAP: begin
				kind_d = KIND_GAP;
				low_d  = gap_q;
			end
			default: kind_d = KIND_ERROR;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (pulse.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q     <= kind_d;
			high_q     <= high_d;
			low_q      <= low_d;
			run_last_q <= cmd.last_run;
		end
	end

	assign pix.ready         = cmd.in_ready;
	assign pulse.valid       = out_valid_q;
	assign pulse.pulse_kind  = kind_q;
	assign pulse.high_time   = high_q;
	assign pulse.low_time    = low_q;
	assign pulse.last_of_run = run_last_q;

	assign stat.in_valid     = pix.valid;
	assign stat.in_last      = pix.last_pixel;
	assign stat.count_zero   = (count_sat == '0);
	assign stat.out_free     = !out_valid_q || pulse.ready;
	assign stat.slot_invalid = code_bad;
	assign stat.bit_done     = (bit_q == '0);
	assign stat.slot_done    = ((CNT_W'(slot_q) + CNT_W'(1)) == count_sat);
	assign stat.last         = last_q;

endmodule

>>> hdl/rlps_ctrl.sv
// Controller: sequences slots, bits, gap and error results per pixel.
module rlps_ctrl
	import rlps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BITS = 2'd1;
	localparam logic [1:0] ST_GAP  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       aborted_q, aborted_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			aborted_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			aborted_q <= aborted_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		aborted_d = aborted_q;
		cmd       = '0;
		cmd.sel   = SEL_BIT;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					cmd.load = 1'b1;
					if (aborted_q) begin
						if (stat.in_last)
							aborted_d = 1'b0;
					end else if (stat.count_zero) begin
						if (stat.in_last)
							state_d = ST_GAP;
					end else begin
						state_d = ST_BITS;
					end
				end
			end
			ST_BITS: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.slot_invalid) begin
						cmd.sel      = SEL_ERR;
						cmd.last_run = 1'b1;
						aborted_d    = !stat.last;
						state_d      = ST_IDLE;
					end else begin
						cmd.next_bit = 1'b1;
						if (stat.bit_done) begin
							if (stat.slot_done) begin
								if (stat.last) begin
									state_d = ST_GAP;
								end else begin
									cmd.last_run = 1'b1;
									state_d      = ST_IDLE;
								end
							end else begin
								cmd.next_slot = 1'b1;
							end
						end
					end
				end
			end
			ST_GAP: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_GAP;
					cmd.last_run = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hdl/rgb_led_pulse_serializer.sv
// Top level of the RGB LED pulse serializer.
//
//   channel    dir   beat
//   pix        in    one pixel: red, green, blue, last_pixel
//   pulse      out   one result: pulse_kind, high_time, low_time, last_of_run
//   cfg_*      in    register write, no read-back
//
// A pixel is taken while the controller is idle, then its results leave one per
// cycle with pulse.ready held high, paced by the result register and controller:
// 8 per slot plus a gap after a last pixel; a slot with an invalid code gives one
// error result in place of its bits, ends the pixel and aborts the frame unless last.
// Aborted-frame pixels and non-last pixels with no slots are taken and give nothing.
// arst_n clears the controller and loads the register defaults.
// pulse.ready low holds the result and stalls the controller.
module rgb_led_pulse_serializer
	import rlps_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rlps_pix_if.sink              pix,
	rlps_pulse_if.source          pulse
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	rlps_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.pulse     (pulse),
		.cmd       (cmd),
		.stat      (stat)
	);

	rlps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

endmodule
